### rtl/core/u8u16_pkg.sv
package u8u16_pkg;

    localparam logic [15:0] REPL_CHAR   = 16'hFFFD;
    localparam int          QUEUE_DEPTH = 4;

    // Code units that one byte produces, queued between decode and output.
    typedef struct packed {
        logic        two;    // unit1 follows unit0
        logic [15:0] unit0;
        logic [15:0] unit1;
    } job_t;

endpackage

### rtl/core/u8u16_front.sv
module u8u16_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         byte_in,
    input  logic               text_end,
    input  logic               q_full,
    output logic               push,
    output u8u16_pkg::job_t    push_job
);

    typedef struct packed {
        logic        emit;
        logic [15:0] unit;
        logic        sup;
        logic [20:0] partial;
        logic [1:0]  needed;
    } lead_t;

    logic [20:0] partial_reg, partial_next;
    logic [1:0]  needed_reg, needed_next;
    logic        sup_reg, sup_next;
    logic        accept;
    logic        emit;
    lead_t       ld;
    logic [20:0] cp;
    logic [20:0] cp_off;
    logic        cp_bad;

    function automatic lead_t take_lead(input logic [7:0] b, input logic last,
                                        input logic sup);
        lead_t r;
        r         = '0;
        r.sup     = sup;
        r.unit    = u8u16_pkg::REPL_CHAR;
        priority if (!b[7])
        begin
            r.emit = 1'b1;
            r.unit = {8'h00, b};
            r.sup  = 1'b0;
        end
        else if (!b[6] || b[7:3] == 5'b11111)
        begin
            // stray continuation or F8-FF: one replacement per run
            r.emit = !sup;
            r.sup  = 1'b1;
        end
        else if (last)
        begin
            r.emit = 1'b1;
            r.sup  = 1'b0;
        end
        else if (!b[5])
        begin
            r.partial = {16'b0, b[4:0]};
            r.needed  = 2'd1;
        end
        else if (!b[4])
        begin
            r.partial = {17'b0, b[3:0]};
            r.needed  = 2'd2;
        end
        else
        begin
            r.partial = {18'b0, b[2:0]};
            r.needed  = 2'd3;
        end
        return r;
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign cp       = {partial_reg[14:0], byte_in[5:0]};
    assign cp_off   = cp - 21'h010000;
    assign cp_bad   = (cp >= 21'h00D800 && cp <= 21'h00DFFF) || cp >= 21'h110000;

    always_comb
    begin
        partial_next   = partial_reg;
        needed_next    = needed_reg;
        sup_next       = sup_reg;
        emit           = 1'b0;
        push_job       = '0;
        push_job.unit0 = u8u16_pkg::REPL_CHAR;
        push_job.unit1 = u8u16_pkg::REPL_CHAR;
        ld             = take_lead(byte_in, text_end, 1'b0);

        priority if (needed_reg == 2'd0)
        begin
            ld             = take_lead(byte_in, text_end, sup_reg);
            emit           = ld.emit;
            push_job.unit0 = ld.unit;
            sup_next       = ld.sup;
            partial_next   = ld.partial;
            needed_next    = ld.needed;
        end
        else if (text_end && needed_reg[1])
        begin
            // truncated: pending bytes and this one collapse into one replacement
            emit         = 1'b1;
            sup_next     = 1'b0;
            partial_next = '0;
            needed_next  = 2'd0;
        end
        else if (byte_in[7:6] == 2'b10)
        begin
            if (needed_reg == 2'd1)
            begin
                partial_next = '0;
                needed_next  = 2'd0;
                emit         = 1'b1;
                priority if (cp_bad)
                begin
                    sup_next = 1'b1;
                end
                else if (cp[20:16] != 5'd0)
                begin
                    push_job.two   = 1'b1;
                    push_job.unit0 = {6'b110110, cp_off[19:10]};
                    push_job.unit1 = {6'b110111, cp_off[9:0]};
                    sup_next       = 1'b0;
                end
                else
                begin
                    push_job.unit0 = cp[15:0];
                    sup_next       = 1'b0;
                end
            end
            else
            begin
                partial_next = cp;
                needed_next  = needed_reg - 2'd1;
            end
        end
        else
        begin
            // broken sequence: replacement, then decode this byte as a lead
            emit           = 1'b1;
            push_job.two   = ld.emit;
            push_job.unit1 = ld.unit;
            sup_next       = ld.sup;
            partial_next   = ld.partial;
            needed_next    = ld.needed;
        end

        if (text_end)
        begin
            partial_next = '0;
            needed_next  = 2'd0;
            sup_next     = 1'b0;
        end
    end

    assign push = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            needed_reg  <= 2'd0;
            sup_reg     <= 1'b0;
        end
        else if (accept)
        begin
            partial_reg <= partial_next;
            needed_reg  <= needed_next;
            sup_reg     <= sup_next;
        end
    end

endmodule

### rtl/core/u8u16_queue.sv
module u8u16_queue #(
    parameter int DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  u8u16_pkg::job_t            push_job,
    output logic                       full,
    input  logic                       pop,
    output logic                       pop_valid,
    output u8u16_pkg::job_t            pop_job,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    u8u16_pkg::job_t entries [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]   level_reg, level_next;
    logic            do_push, do_pop;

    assign full      = (level_reg == LW'(DEPTH));
    assign pop_valid = (level_reg != '0);
    assign pop_job   = entries[rd_ptr_reg];
    assign level     = level_reg;
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            level_next = level_reg + 1'b1;
        else if (do_pop && !do_push)
            level_next = level_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

### rtl/core/u8u16_back.sv
module u8u16_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  u8u16_pkg::job_t q_job,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [15:0]     code_unit,
    output logic            last_of_run
);

    logic        valid_reg, valid_next;
    logic [15:0] unit_reg, unit_next;
    logic        last_reg, last_next;
    logic        second_reg, second_next;
    logic [15:0] hold_reg, hold_next;
    logic        advance;

    assign advance     = !valid_reg || out_ready;
    assign pop         = advance && !second_reg && q_valid;
    assign out_valid   = valid_reg;
    assign code_unit   = unit_reg;
    assign last_of_run = last_reg;

    always_comb
    begin
        valid_next  = valid_reg;
        unit_next   = unit_reg;
        last_next   = last_reg;
        second_next = second_reg;
        hold_next   = hold_reg;
        if (advance)
        begin
            priority if (second_reg)
            begin
                valid_next  = 1'b1;
                unit_next   = hold_reg;
                last_next   = 1'b1;
                second_next = 1'b0;
            end
            else if (q_valid)
            begin
                valid_next  = 1'b1;
                unit_next   = q_job.unit0;
                last_next   = !q_job.two;
                second_next = q_job.two;
                hold_next   = q_job.unit1;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unit_reg <= unit_next;
        last_reg <= last_next;
        hold_reg <= hold_next;
    end

endmodule

### rtl/core/utf8_to_utf16_transcoder.sv
// UTF-8 to UTF-16 stream transcoder. One byte enters per cycle on s_axis while the
// job queue (QUEUE_DEPTH entries) has room; code units leave on m_axis at one per
// cycle while m_axis_tready is high, from a registered output stage. A byte yields
// zero, one or two units; tlast marks the last unit a byte caused. Bytes that yield
// two units (surrogate pairs, or a replacement followed by the byte that broke a
// sequence) hold back the next queued job until their second unit has left, so the
// sustained byte rate is set by the output port and reaches one byte per cycle
// only for single units. The queue lets decode run ahead while m_axis stalls.
// s_axis tlast ends the text: any unfinished sequence becomes one U+FFFD and the
// decoder returns to its reset state. Overlong forms are passed, not rejected.
module utf8_to_utf16_transcoder #(
    parameter int QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic        s_axis_tlast,   // text_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] code_unit
    output logic        m_axis_tlast    // last_of_run
);

    logic                              q_full;
    logic                              push;
    u8u16_pkg::job_t                   push_job;
    logic                              pop;
    logic                              pop_valid;
    u8u16_pkg::job_t                   pop_job;
    logic [$clog2(QUEUE_DEPTH+1)-1:0]  q_level;

    u8u16_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .byte_in  (s_axis_tdata),
        .text_end (s_axis_tlast),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_job   (pop_job),
        .level     (q_level)
    );

    u8u16_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (pop_valid),
        .q_job       (pop_job),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .code_unit   (m_axis_tdata),
        .last_of_run (m_axis_tlast)
    );

    // second unit of a pair is staged in the back end and follows at once
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
    else $error("second unit of a pair did not follow");

    // a high surrogate leading a pair is always followed by a low surrogate
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast && m_axis_tdata[15:10] == 6'b110110
        |=> m_axis_tdata[15:10] == 6'b110111)
    else $error("high surrogate without low surrogate");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("job queue overflow");

    // decode stalls only on a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == !q_full)
    else $error("input ready does not track queue space");

endmodule

### sim/u8u16_unit_monitor.sv
`timescale 1ns / 100ps

// Watches both streams, decodes every accepted byte on its own and compares
// the code units and last flags that leave the block against the ones predicted.
module u8u16_unit_monitor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] byte_in
    input  logic        s_tlast,    // text_end
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,    // [15:0] code_unit
    input  logic        m_tlast,    // last_of_run
    output int          units_pending,
    output int          fail_count
);

    localparam logic [20:0] SURR_FIRST   = 21'h00D800;
    localparam logic [20:0] SURR_LAST    = 21'h00DFFF;
    localparam logic [20:0] PLANE1_START = 21'h010000;
    localparam logic [20:0] POINT_LIMIT  = 21'h110000;
    localparam logic [15:0] HIGH_BASE    = 16'hD800;
    localparam logic [15:0] LOW_BASE     = 16'hDC00;

    typedef struct {
        logic [15:0] unit;
        logic        last;
    } unit_item_t;

    unit_item_t  expected_units [$];

    // decoder state
    logic [20:0] point_acc;
    logic [1:0]  need_cnt;
    logic [1:0]  held_cnt;
    logic        suppress;

    logic [15:0] unit_buf [2];
    int          unit_cnt;

    function automatic void put_unit(input logic [15:0] v);
        if (unit_cnt < 2)
        begin
            unit_buf[unit_cnt] = v;
            unit_cnt++;
        end
    endfunction

    function automatic void drop_sequence();
        point_acc = '0;
        need_cnt  = '0;
        held_cnt  = '0;
    endfunction

    function automatic void encode_point(input logic [20:0] cp);
        logic [20:0] offs;
        if ((cp >= SURR_FIRST && cp <= SURR_LAST) || cp >= POINT_LIMIT)
        begin
            put_unit(u8u16_pkg::REPL_CHAR);
            suppress = 1'b1;
        end
        else if (cp >= PLANE1_START)
        begin
            offs = cp - PLANE1_START;
            put_unit(HIGH_BASE + offs[19:10]);
            put_unit(LOW_BASE + offs[9:0]);
            suppress = 1'b0;
        end
        else
        begin
            put_unit(cp[15:0]);
            suppress = 1'b0;
        end
    endfunction

    function automatic void start_sequence(input logic [7:0] b, input logic fin);
        if (b < 8'h80)
        begin
            put_unit({8'h00, b});
            suppress = 1'b0;
        end
        else if (b < 8'hC0 || b >= 8'hF8)
        begin
            // stray byte: one replacement per run
            if (!suppress)
                put_unit(u8u16_pkg::REPL_CHAR);
            suppress = 1'b1;
        end
        else if (fin)
        begin
            put_unit(u8u16_pkg::REPL_CHAR);
            suppress = 1'b0;
        end
        else
        begin
            if (b < 8'hE0)
            begin
                point_acc = {16'd0, b[4:0]};
                need_cnt  = 2'd1;
            end
            else if (b < 8'hF0)
            begin
                point_acc = {17'd0, b[3:0]};
                need_cnt  = 2'd2;
            end
            else
            begin
                point_acc = {18'd0, b[2:0]};
                need_cnt  = 2'd3;
            end
            held_cnt = 2'd1;
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic fin);
        logic [20:0] cp;
        unit_item_t  item;
        unit_cnt = 0;
        if (need_cnt == 2'd0)
            start_sequence(b, fin);
        else if (fin && need_cnt >= 2'd2)
        begin
            // text cut short: current byte is swallowed
            put_unit(u8u16_pkg::REPL_CHAR);
            suppress = 1'b0;
            drop_sequence();
        end
        else if (b[7:6] == 2'b10)
        begin
            point_acc = {point_acc[14:0], b[5:0]};
            need_cnt  = need_cnt - 2'd1;
            held_cnt  = held_cnt + 2'd1;
            if (need_cnt == 2'd0)
            begin
                cp = point_acc;
                drop_sequence();
                encode_point(cp);
            end
        end
        else
        begin
            put_unit(u8u16_pkg::REPL_CHAR);
            suppress = 1'b0;
            drop_sequence();
            start_sequence(b, fin);
        end
        if (fin)
        begin
            drop_sequence();
            suppress = 1'b0;
        end
        for (int i = 0; i < unit_cnt; i++)
        begin
            item.unit      = unit_buf[i];
            item.last      = (i == unit_cnt - 1);
            expected_units = {expected_units, item};
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        unit_item_t exp_item;
        if (!rst_n)
        begin
            expected_units.delete();
            drop_sequence();
            suppress      = 1'b0;
            fail_count    = 0;
            units_pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_units.size() == 0)
                begin
                    $error("code_unit: expected none, actual %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    exp_item = expected_units.pop_front();
                    if (m_tdata !== exp_item.unit)
                    begin
                        $error("code_unit: expected %h, actual %h", exp_item.unit, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== exp_item.last)
                    begin
                        $error("last_of_run: expected %b, actual %b", exp_item.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tlast);
            units_pending <= expected_units.size();
        end
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int HOLD_CYCLES    = 300;
    localparam int STALL_LIMIT    = 4000;
    localparam int ITEMS_PER_PASS = 235;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    int          units_pending;
    int          fail_count;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    logic        hold_armed = 1'b0;
    int          hold_count;
    int          quiet_cycles = 0;
    int          bytes_sent = 0;

    always #10 clk = ~clk;

    utf8_to_utf16_transcoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast)
    );

    u8u16_unit_monitor u_monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .units_pending (units_pending),
        .fail_count    (fail_count)
    );

    // receiver: random stalls, plus one long hold-off once armed
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            hold_count <= 0;
        end
        else if (hold_armed && hold_count < HOLD_CYCLES)
        begin
            m_tready   <= 1'b0;
            hold_count <= hold_count + 1;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("utf8_to_utf16_transcoder verification failed");
                    $finish;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (units_pending != 0);
    endtask

    // mostly well-formed sequences with random payload, some noise
    task automatic send_random_chunk();
        logic [7:0] seq [4];
        int         len;
        int         kind;
        logic       fin;
        kind = $urandom_range(99);
        if (kind < 22)
        begin
            len    = 1;
            seq[0] = 8'($urandom_range(127));
        end
        else if (kind < 40)
        begin
            len    = 2;
            seq[0] = 8'hC0 | 8'($urandom_range(31));
        end
        else if (kind < 58)
        begin
            len    = 3;
            seq[0] = 8'hE0 | 8'($urandom_range(15));
        end
        else if (kind < 72)
        begin
            len    = 4;
            seq[0] = 8'hF0 | 8'($urandom_range(7));
        end
        else if (kind < 78)
        begin
            // lands in the surrogate range
            len    = 3;
            seq[0] = 8'hED;
        end
        else if (kind < 86)
        begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
                seq[i] = $urandom_range(1) ? (8'h80 | 8'($urandom_range(63)))
                                           : (8'hF8 | 8'($urandom_range(7)));
        end
        else if (kind < 94)
        begin
            // sequence cut short: only a prefix of it is sent
            len    = $urandom_range(2, 4);
            seq[0] = (len == 2) ? (8'hC0 | 8'($urandom_range(31))) :
                     (len == 3) ? (8'hE0 | 8'($urandom_range(15))) :
                                  (8'hF0 | 8'($urandom_range(7)));
        end
        else
        begin
            len    = 1;
            seq[0] = 8'($urandom_range(255));
        end
        if (kind >= 40 && kind < 78)
        begin
            for (int i = 1; i < len; i++)
                seq[i] = 8'h80 | 8'($urandom_range(63));
            if (kind >= 72)
                seq[1] = 8'hA0 | 8'($urandom_range(31));
        end
        else if (kind >= 86 && kind < 94)
        begin
            for (int i = 1; i < len; i++)
                seq[i] = 8'h80 | 8'($urandom_range(63));
            len = $urandom_range(1, len - 1);
        end
        for (int i = 0; i < len; i++)
        begin
            fin = (i == len - 1) ? ($urandom_range(14) == 0) : ($urandom_range(59) == 0);
            send_byte(seq[i], fin);
        end
    endtask

    task automatic send_directed();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        // surrogate pair
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b0);
        // stray run, second one suppressed
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        // encoded surrogate rejected
        send_byte(8'hED, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b0);
        // broken sequence: replacement then the new lead
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b0);
        // lead on end of text
        send_byte(8'hE2, 1'b1);
        // end of text with two or more bytes still missing
        send_byte(8'hF0, 1'b0);
        send_byte(8'hC3, 1'b1);
        // end of text with one byte missing completes normally
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b1);
        // above the last plane
        send_byte(8'hF4, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        // overlong passes
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
    endtask

    initial
    begin
        int tx_pct [4];
        int rx_pct [4];
        tx_pct = '{0, 53, 0, 31};
        rx_pct = '{0, 0, 53, 31};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_directed();
        wait_drain();
        for (int p = 0; p < 4; p++)
        begin
            tx_idle_pct = tx_pct[p];
            rx_stall_pct <= rx_pct[p];
            if (p == 0)
                hold_armed <= 1'b1;
            bytes_sent = 0;
            while (bytes_sent < ITEMS_PER_PASS)
                send_random_chunk();
            wait_drain();
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("utf8_to_utf16_transcoder verification clean");
        else
            $display("utf8_to_utf16_transcoder verification failed");
        $finish;
    end

endmodule
